// ===== rtl/core/bmhc_pkg.sv =====
// Shared types, codes and constants of the boiler mode hysteresis controller.
// No dependencies; imported by every module under rtl/core.
package bmhc_pkg;

    localparam int TEMP_W = 12;
    localparam int CFG_IDX_W = 3;
    localparam int IN_TDATA_W = 40;
    localparam int OUT_TDATA_W = 8;

    // Valve position codes
    localparam logic WATER_VALVE_CODE = 1'b0;
    localparam logic BUFFER_VALVE_CODE = 1'b1;

    // Weekly schedule
    localparam logic [2:0] DAY_SUNDAY = 3'd0;
    localparam logic [2:0] DAY_SATURDAY = 3'd6;
    localparam logic [4:0] SAT_FIRST_HOUR = 5'd5;
    localparam logic [4:0] SAT_LAST_HOUR = 5'd12;
    localparam logic [4:0] SUN_FIRST_HOUR = 5'd7;
    localparam logic [4:0] SUN_LAST_HOUR = 5'd12;
    localparam logic [4:0] WKD_AM_FIRST_HOUR = 5'd4;
    localparam logic [4:0] WKD_AM_LAST_HOUR = 5'd8;
    localparam logic [4:0] WKD_PM_FIRST_HOUR = 5'd19;
    localparam logic [4:0] WKD_PM_LAST_HOUR = 5'd21;

    // Register reset values, tenths of a degree
    localparam logic signed [TEMP_W-1:0] WATER_ON_RESET = 12'sd530;
    localparam logic signed [TEMP_W-1:0] WATER_OFF_RESET = 12'sd580;
    localparam logic signed [TEMP_W-1:0] BUFFER_ON_RESET = 12'sd330;
    localparam logic signed [TEMP_W-1:0] BUFFER_OFF_RESET = 12'sd360;

    typedef enum logic [1:0] {
        HEAT_OFF = 2'd0,
        HEAT_TANK = 2'd1,
        HEAT_BUF = 2'd2
    } t_mode;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_WATER_ON = 3'd0,
        REG_WATER_OFF = 3'd1,
        REG_BUFFER_ON = 3'd2,
        REG_BUFFER_OFF = 3'd3,
        REG_WATER_EN = 3'd4,
        REG_BUFFER_EN = 3'd5,
        REG_SCHEDULE_EN = 3'd6
    } t_cfg_idx;

    typedef struct packed {
        logic signed [TEMP_W-1:0] water_on_temp;
        logic signed [TEMP_W-1:0] water_off_temp;
        logic signed [TEMP_W-1:0] buffer_on_temp;
        logic signed [TEMP_W-1:0] buffer_off_temp;
        logic water_enable;
        logic buffer_enable;
        logic schedule_enable;
    } t_cfg;

    typedef struct packed {
        logic signed [TEMP_W-1:0] water_temp;
        logic signed [TEMP_W-1:0] buffer_temp;
        logic [2:0] weekday;
        logic [4:0] hour_of_day;
        logic stove_feedback;
        logic valve_feedback;
    } t_in_item;

    typedef struct packed {
        logic emit;
        logic stove_command;
        logic valve_command;
        t_mode new_mode;
        logic feedback_alert;
    } t_decision;

endpackage

// ===== rtl/core/bmhc_window.sv =====
// Time-of-day window decode from the fixed weekly schedule.
// Depends on bmhc_pkg for day codes and hour limits.
module bmhc_window import bmhc_pkg::*; (
    input  logic [2:0] i_weekday,
    input  logic [4:0] i_hour_of_day,
    input  logic       i_schedule_enable,
    output logic       o_window_open
);

    logic w_sat;
    logic w_sun;
    logic w_wkd;

    assign w_sat = (i_hour_of_day >= SAT_FIRST_HOUR) && (i_hour_of_day <= SAT_LAST_HOUR);
    assign w_sun = (i_hour_of_day >= SUN_FIRST_HOUR) && (i_hour_of_day <= SUN_LAST_HOUR);
    assign w_wkd = ((i_hour_of_day >= WKD_AM_FIRST_HOUR) && (i_hour_of_day <= WKD_AM_LAST_HOUR))
                || ((i_hour_of_day >= WKD_PM_FIRST_HOUR) && (i_hour_of_day <= WKD_PM_LAST_HOUR));

    always_comb begin
        if (!i_schedule_enable) begin
            o_window_open = 1'b1;
        end else if (i_weekday == DAY_SATURDAY) begin
            o_window_open = w_sat;
        end else if (i_weekday == DAY_SUNDAY) begin
            o_window_open = w_sun;
        end else begin
            // weekday code 7 falls in with the working days
            o_window_open = w_wkd;
        end
    end

endmodule

// ===== rtl/core/bmhc_mode.sv =====
// Hysteresis mode decision for one poll item: first-tick takeover, mode step,
// one re-evaluation after a fall to stopped, and command/alert generation.
// Depends on bmhc_pkg for types and valve codes.
module bmhc_mode import bmhc_pkg::*; (
    input  t_in_item  i_item,
    input  t_cfg      i_cfg,
    input  t_mode     i_mode,
    input  logic      i_started,
    input  logic      i_window_open,
    output t_decision o_dec
);

    t_mode w_start_mode;
    t_mode w_stop_eval;
    t_mode w_mode;
    logic  w_water_need;
    logic  w_water_done;
    logic  w_buffer_need;
    logic  w_buffer_done;
    logic  w_stove;
    logic  w_valve;
    logic  w_mismatch;

    assign w_water_need = ($signed(i_item.water_temp) <= $signed(i_cfg.water_on_temp))
                       && i_cfg.water_enable;
    assign w_water_done = $signed(i_item.water_temp) >= $signed(i_cfg.water_off_temp);
    assign w_buffer_need = ($signed(i_item.buffer_temp) <= $signed(i_cfg.buffer_on_temp))
                        && i_cfg.buffer_enable;
    assign w_buffer_done = ($signed(i_item.buffer_temp) >= $signed(i_cfg.buffer_off_temp))
                        && i_cfg.buffer_enable;

    // On the first item take the mode over from the feedback
    always_comb begin
        if (!i_started) begin
            if (!i_item.stove_feedback) begin
                w_start_mode = HEAT_OFF;
            end else if (i_item.valve_feedback == WATER_VALVE_CODE) begin
                w_start_mode = HEAT_TANK;
            end else begin
                w_start_mode = HEAT_BUF;
            end
        end else begin
            w_start_mode = i_mode;
        end
    end

    always_comb begin
        if (w_water_need && i_window_open) begin
            w_stop_eval = HEAT_TANK;
        end else if (w_buffer_need) begin
            w_stop_eval = HEAT_BUF;
        end else begin
            w_stop_eval = HEAT_OFF;
        end
    end

    // A fall to stopped takes the stopped evaluation in the same item
    always_comb begin
        unique case (w_start_mode)
            HEAT_OFF:  w_mode = w_stop_eval;
            HEAT_TANK: w_mode = (w_water_done || !i_window_open) ? w_stop_eval : HEAT_TANK;
            default:   w_mode = (w_water_need || w_buffer_done) ? w_stop_eval : HEAT_BUF;
        endcase
    end

    assign w_stove = (w_mode != HEAT_OFF);
    assign w_valve = (w_mode == HEAT_BUF) ? BUFFER_VALVE_CODE : WATER_VALVE_CODE;
    assign w_mismatch = (i_item.stove_feedback != w_stove) || (i_item.valve_feedback != w_valve);

    always_comb begin
        o_dec.stove_command = w_stove;
        o_dec.valve_command = w_valve;
        o_dec.new_mode = w_mode;
        o_dec.feedback_alert = (w_mode == w_start_mode);
        o_dec.emit = (w_mode != w_start_mode) || w_mismatch;
    end

endmodule

// ===== rtl/core/boiler_mode_hysteresis_controller.sv =====
// Channel     Dir  Width  Contents
// s_axis      in   40     water_temp, buffer_temp, weekday, hour_of_day, feedbacks
// m_axis      out  8      stove_command, valve_command, new_mode, feedback_alert
// cfg write   in   12     seven threshold/enable registers, index 0..6
//
// One item per cycle while the output is not held: an item sits in the input register while the
// window and mode logic decide; the result lands in the output register.
// Mode state updates on the same edge as the output register, so the next item sees it at once.
// A held output stalls only the input register; an item with no result
// passes whenever the output register is free or being taken.
// Synchronous active-low reset: stopped mode, first tick pending, reset thresholds.
// Top level; depends on bmhc_pkg, bmhc_window and bmhc_mode.
module boiler_mode_hysteresis_controller import bmhc_pkg::*; (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    // [11:0] water_temp, [23:12] buffer_temp, [26:24] weekday, [31:27] hour_of_day,
    // [32] stove_feedback, [33] valve_feedback, [39:34] zero
    input  logic [IN_TDATA_W-1:0]  s_axis_tdata,
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    // [0] stove_command, [1] valve_command, [3:2] new_mode, [4] feedback_alert, [7:5] zero
    output logic [OUT_TDATA_W-1:0] m_axis_tdata,
    input  logic                   i_cfg_we,
    input  logic [CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [TEMP_W-1:0]      i_cfg_wdata
);

    t_cfg      r_cfg;
    logic      r_s1_valid;
    t_in_item  r_s1;
    t_mode     r_mode;
    logic      r_started;
    logic      r_out_valid;
    t_decision r_out;
    t_decision w_dec;
    logic      w_window_open;
    logic      w_advance;

    assign w_advance = r_s1_valid && (!r_out_valid || m_axis_tready);
    assign s_axis_tready = !r_s1_valid || w_advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.water_on_temp <= WATER_ON_RESET;
            r_cfg.water_off_temp <= WATER_OFF_RESET;
            r_cfg.buffer_on_temp <= BUFFER_ON_RESET;
            r_cfg.buffer_off_temp <= BUFFER_OFF_RESET;
            r_cfg.water_enable <= 1'b0;
            r_cfg.buffer_enable <= 1'b0;
            r_cfg.schedule_enable <= 1'b1;
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_idx))
                REG_WATER_ON:    r_cfg.water_on_temp <= i_cfg_wdata;
                REG_WATER_OFF:   r_cfg.water_off_temp <= i_cfg_wdata;
                REG_BUFFER_ON:   r_cfg.buffer_on_temp <= i_cfg_wdata;
                REG_BUFFER_OFF:  r_cfg.buffer_off_temp <= i_cfg_wdata;
                REG_WATER_EN:    r_cfg.water_enable <= i_cfg_wdata[0];
                REG_BUFFER_EN:   r_cfg.buffer_enable <= i_cfg_wdata[0];
                REG_SCHEDULE_EN: r_cfg.schedule_enable <= i_cfg_wdata[0];
                default: ;
            endcase
        end
    end

    // Input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_s1_valid <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            r_s1.water_temp <= s_axis_tdata[11:0];
            r_s1.buffer_temp <= s_axis_tdata[23:12];
            r_s1.weekday <= s_axis_tdata[26:24];
            r_s1.hour_of_day <= s_axis_tdata[31:27];
            r_s1.stove_feedback <= s_axis_tdata[32];
            r_s1.valve_feedback <= s_axis_tdata[33];
        end
    end

    bmhc_window u_window (
        .i_weekday         (r_s1.weekday),
        .i_hour_of_day     (r_s1.hour_of_day),
        .i_schedule_enable (r_cfg.schedule_enable),
        .o_window_open     (w_window_open)
    );

    bmhc_mode u_mode (
        .i_item        (r_s1),
        .i_cfg         (r_cfg),
        .i_mode        (r_mode),
        .i_started     (r_started),
        .i_window_open (w_window_open),
        .o_dec         (w_dec)
    );

    // Mode state and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= HEAT_OFF;
            r_started <= 1'b0;
            r_out_valid <= 1'b0;
        end else if (w_advance) begin
            r_mode <= w_dec.new_mode;
            r_started <= 1'b1;
            r_out_valid <= w_dec.emit;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_advance && w_dec.emit) begin
            r_out <= w_dec;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata = {3'b000, r_out.feedback_alert, r_out.new_mode,
                           r_out.valve_command, r_out.stove_command};

`ifndef SYNTHESIS
    // A waiting result always reports the mode now held
    a_out_mode_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (r_out.new_mode == r_mode))
        else $error("pending result mode differs from held mode");

    // No item consumed yet: mode stays at its reset value
    a_not_started_stopped: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_started |-> (r_mode == HEAT_OFF))
        else $error("mode moved before first item");

    // An item without result leaves the mode alone once started
    a_silent_keeps_mode: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_advance && !w_dec.emit && r_started) |=> (r_mode == $past(r_mode)))
        else $error("mode changed without a result");

    // An alert result never carries a mode change
    a_alert_no_change: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_advance && w_dec.emit && w_dec.feedback_alert && r_started)
            |-> (w_dec.new_mode == r_mode))
        else $error("alert raised on a mode change");
`endif

endmodule

// ===== bench/boiler_mode_hysteresis_controller_tb.sv =====
// Self-checking bench for boiler_mode_hysteresis_controller: a directed table, then random poll
// ticks over several register settings, checked against typed results or an in-bench mode predictor.
// Depends on bmhc_pkg and the RTL under rtl/core.
`timescale 1ns / 100ps

module boiler_mode_hysteresis_controller_tb;
    import bmhc_pkg::*;

    localparam int PIPE_CYCLES = 4;
    localparam int N_PHASES = 9;
    localparam int PHASE_TICKS = 92;

    typedef enum logic {
        ROW_TICK,
        ROW_WRITE
    } t_row_op;

    typedef struct packed {
        logic stove_cmd;
        logic valve_cmd;
        t_mode mode;
        logic alert;
    } t_result;

    typedef struct packed {
        t_row_op op;
        t_cfg_idx reg_idx;
        logic [TEMP_W-1:0] reg_val;
        t_in_item tick;
        logic typed;
        logic emit;
        t_result res;
    } t_row;

    logic i_clk = 1'b0;
    logic i_rst_n;
    logic s_axis_tvalid;
    logic s_axis_tready;
    logic [IN_TDATA_W-1:0] s_axis_tdata;
    logic m_axis_tvalid;
    logic m_axis_tready;
    logic [OUT_TDATA_W-1:0] m_axis_tdata;
    logic i_cfg_we;
    logic [CFG_IDX_W-1:0] i_cfg_idx;
    logic [TEMP_W-1:0] i_cfg_wdata;

    // Predictor copy of the registers and the mode state
    logic signed [TEMP_W-1:0] thr_water_on = WATER_ON_RESET;
    logic signed [TEMP_W-1:0] thr_water_off = WATER_OFF_RESET;
    logic signed [TEMP_W-1:0] thr_buffer_on = BUFFER_ON_RESET;
    logic signed [TEMP_W-1:0] thr_buffer_off = BUFFER_OFF_RESET;
    logic water_on = 1'b0;
    logic buffer_on = 1'b0;
    logic sched_on = 1'b1;
    t_mode cur_mode = HEAT_OFF;
    logic first_seen = 1'b0;

    t_result pending_cmds[$];
    t_row plan[$];
    bit calm = 1'b0;
    int mismatches = 0;
    int n_ticks = 0;
    int n_changes = 0;
    int n_alerts = 0;
    int n_writes = 0;
    int n_settings = 0;

    boiler_mode_hysteresis_controller dut (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata),
        .i_cfg_we(i_cfg_we),
        .i_cfg_idx(i_cfg_idx),
        .i_cfg_wdata(i_cfg_wdata)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    initial begin
        #400000;
        $display("CHECKS FAILED");
        $finish;
    end

    function automatic bit burn_window_open(logic [2:0] wd, logic [4:0] hr);
        if (!sched_on)
            return 1'b1;
        if (wd == DAY_SATURDAY)
            return hr >= SAT_FIRST_HOUR && hr <= SAT_LAST_HOUR;
        if (wd == DAY_SUNDAY)
            return hr >= SUN_FIRST_HOUR && hr <= SUN_LAST_HOUR;
        return (hr >= WKD_AM_FIRST_HOUR && hr <= WKD_AM_LAST_HOUR) ||
               (hr >= WKD_PM_FIRST_HOUR && hr <= WKD_PM_LAST_HOUR);
    endfunction

    // Advance the mode machine by one tick; return 1 when a command goes out.
    function automatic bit next_boiler_cmd(input t_in_item it, output t_result r);
        logic signed [TEMP_W-1:0] tw;
        logic signed [TEMP_W-1:0] tb;
        bit win, wneed, again, mis, emit;
        t_mode m;
        logic st, vl;
        tw = it.water_temp;
        tb = it.buffer_temp;
        win = burn_window_open(it.weekday, it.hour_of_day);
        wneed = (tw <= thr_water_on) && water_on;
        if (!first_seen) begin
            if (!it.stove_feedback)
                cur_mode = HEAT_OFF;
            else if (it.valve_feedback == WATER_VALVE_CODE)
                cur_mode = HEAT_TANK;
            else
                cur_mode = HEAT_BUF;
            first_seen = 1'b1;
        end
        m = cur_mode;
        again = 1'b1;
        // a fall to stopped gets one more look in the same tick
        while (again) begin
            again = 1'b0;
            case (m)
                HEAT_OFF: begin
                    if (wneed && win)
                        m = HEAT_TANK;
                    else if (tb <= thr_buffer_on && buffer_on)
                        m = HEAT_BUF;
                end
                HEAT_TANK: begin
                    if (tw >= thr_water_off || !win) begin
                        m = HEAT_OFF;
                        again = 1'b1;
                    end
                end
                default: begin
                    if (wneed || (tb >= thr_buffer_off && buffer_on)) begin
                        m = HEAT_OFF;
                        again = 1'b1;
                    end
                end
            endcase
        end
        st = (m != HEAT_OFF);
        vl = (m == HEAT_BUF) ? BUFFER_VALVE_CODE : WATER_VALVE_CODE;
        mis = (it.stove_feedback != st) || (it.valve_feedback != vl);
        r.stove_cmd = st;
        r.valve_cmd = vl;
        r.mode = m;
        r.alert = (m == cur_mode);
        emit = (m != cur_mode) || mis;
        if (emit)
            cur_mode = m;
        return emit;
    endfunction

    function automatic t_row tick_row(int tw, int tb, int wd, int hr, bit st, bit vl);
        t_row r;
        r = '0;
        r.op = ROW_TICK;
        r.tick.water_temp = 12'(tw);
        r.tick.buffer_temp = 12'(tb);
        r.tick.weekday = 3'(wd);
        r.tick.hour_of_day = 5'(hr);
        r.tick.stove_feedback = st;
        r.tick.valve_feedback = vl;
        return r;
    endfunction

    function automatic t_row typed_row(t_row r, bit emit, bit st, bit vl, t_mode m, bit al);
        r.typed = 1'b1;
        r.emit = emit;
        r.res.stove_cmd = st;
        r.res.valve_cmd = vl;
        r.res.mode = m;
        r.res.alert = al;
        return r;
    endfunction

    function automatic t_row write_row(t_cfg_idx idx, int val);
        t_row r;
        r = '0;
        r.op = ROW_WRITE;
        r.reg_idx = idx;
        r.reg_val = 12'(val);
        return r;
    endfunction

    // Temperatures mostly hover around the active thresholds.
    function automatic int near_temp(int lo, int hi);
        int v;
        case ($urandom_range(0, 15))
            0: v = int'($urandom_range(0, 4095)) - 2048;
            1, 2, 3: v = int'($urandom_range(0, 3000)) - 1000;
            default: begin
                v = int'($urandom_range(0, hi - lo + 80)) + lo - 40;
                v = (v < -1000) ? -1000 : (v > 2000) ? 2000 : v;
            end
        endcase
        return v;
    endfunction

    task automatic push_tick(input t_row r);
        t_result res;
        bit emit;
        if (!calm && $urandom_range(0, 6) == 0) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 11)) @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= {6'b0, r.tick.valve_feedback, r.tick.stove_feedback,
                         r.tick.hour_of_day, r.tick.weekday,
                         r.tick.buffer_temp, r.tick.water_temp};
        @(posedge i_clk);
        while (!s_axis_tready)
            @(posedge i_clk);
        n_ticks++;
        emit = next_boiler_cmd(r.tick, res);
        if (r.typed) begin
            emit = r.emit;
            res = r.res;
        end
        if (emit) begin
            pending_cmds.push_back(res);
            if (res.alert)
                n_alerts++;
            else
                n_changes++;
        end
        @(negedge i_clk);
    endtask

    // Hold the sender until every command is back and the pipe is empty.
    task automatic settle();
        s_axis_tvalid <= 1'b0;
        while (pending_cmds.size() != 0)
            @(negedge i_clk);
        repeat (PIPE_CYCLES) @(negedge i_clk);
    endtask

    task automatic write_reg(t_cfg_idx idx, logic [TEMP_W-1:0] val);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_wdata <= val;
        case (idx)
            REG_WATER_ON: thr_water_on = val;
            REG_WATER_OFF: thr_water_off = val;
            REG_BUFFER_ON: thr_buffer_on = val;
            REG_BUFFER_OFF: thr_buffer_off = val;
            REG_WATER_EN: water_on = val[0];
            REG_BUFFER_EN: buffer_on = val[0];
            REG_SCHEDULE_EN: sched_on = val[0];
            default: ;
        endcase
        n_writes++;
        @(negedge i_clk);
    endtask

    task automatic log_mismatch(string what, t_result want, logic [OUT_TDATA_W-1:0] got);
        mismatches++;
        if (mismatches <= 10)
            $display({"mismatch on %s at %0t: want stove=%0d valve=%0d mode=%0d alert=%0d,",
                      " got tdata=%02h"},
                     what, $time, want.stove_cmd, want.valve_cmd, want.mode, want.alert, got);
    endtask

    // Output side: random stall bursts, none once the run goes calm.
    initial begin
        m_axis_tready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (!calm && $urandom_range(0, 9) == 0) begin
                m_axis_tready <= 1'b0;
                repeat ($urandom_range(1, 11)) @(negedge i_clk);
            end
            m_axis_tready <= 1'b1;
        end
    end

    always @(posedge i_clk) begin
        t_result want;
        logic [OUT_TDATA_W-1:0] got;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got = m_axis_tdata;
            if (pending_cmds.size() == 0) begin
                log_mismatch("unexpected item", '0, got);
            end else begin
                want = pending_cmds.pop_front();
                if (got[0] !== want.stove_cmd)
                    log_mismatch("stove_command", want, got);
                if (got[1] !== want.valve_cmd)
                    log_mismatch("valve_command", want, got);
                if (got[3:2] !== want.mode)
                    log_mismatch("new_mode", want, got);
                if (got[4] !== want.alert)
                    log_mismatch("feedback_alert", want, got);
                if (got[7:5] !== 3'b000)
                    log_mismatch("padding", want, got);
            end
        end
    end

    initial begin
        t_row row;
        bit cfg_busy;
        bit wen, ben, sen, st, vl;
        int p, k, n, lo, hi, tw, tb;
        int ph_on[2];
        int ph_off[2];
        logic [TEMP_W-1:0] junk;

        cfg_busy = 1'b0;
        i_rst_n = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        i_cfg_we = 1'b0;
        i_cfg_idx = '0;
        i_cfg_wdata = '0;

        // Reset settings: both loops off, schedule on. The first tick takes its mode
        // from the feedback.
        plan.push_back(typed_row(tick_row(500, 300, 1, 5, 1, WATER_VALVE_CODE),
                                 0, 0, WATER_VALVE_CODE, HEAT_OFF, 0));
        plan.push_back(typed_row(tick_row(500, 300, 1, 10, 1, WATER_VALVE_CODE),
                                 1, 0, WATER_VALVE_CODE, HEAT_OFF, 0));
        plan.push_back(typed_row(tick_row(500, 300, 1, 10, 1, WATER_VALVE_CODE),
                                 1, 0, WATER_VALVE_CODE, HEAT_OFF, 1));
        plan.push_back(typed_row(tick_row(500, 300, 1, 10, 0, BUFFER_VALVE_CODE),
                                 1, 0, WATER_VALVE_CODE, HEAT_OFF, 1));
        plan.push_back(typed_row(tick_row(500, 300, 1, 10, 0, WATER_VALVE_CODE),
                                 0, 0, WATER_VALVE_CODE, HEAT_OFF, 0));
        plan.push_back(write_row(REG_WATER_EN, 1));
        plan.push_back(write_row(REG_BUFFER_EN, 1));
        // thresholds exactly on the on and off marks
        plan.push_back(tick_row(530, 330, 6, 5, 0, WATER_VALVE_CODE));
        plan.push_back(tick_row(579, 330, 6, 12, 1, WATER_VALVE_CODE));
        plan.push_back(tick_row(580, 330, 6, 12, 1, WATER_VALVE_CODE));
        plan.push_back(tick_row(2000, 360, 6, 12, 1, BUFFER_VALVE_CODE));
        plan.push_back(tick_row(-1000, 2000, 0, 6, 0, WATER_VALVE_CODE));
        plan.push_back(tick_row(-1000, 2000, 0, 7, 0, WATER_VALVE_CODE));
        // weekday 7 follows the workday windows; hours past 23 close the window
        plan.push_back(tick_row(-1000, 2000, 7, 4, 1, WATER_VALVE_CODE));
        plan.push_back(tick_row(-1000, -1000, 7, 24, 1, WATER_VALVE_CODE));
        plan.push_back(tick_row(-1000, -1000, 3, 31, 1, BUFFER_VALVE_CODE));
        plan.push_back(tick_row(0, 0, 5, 21, 1, BUFFER_VALVE_CODE));
        plan.push_back(tick_row(100, 0, 5, 19, 1, BUFFER_VALVE_CODE));
        plan.push_back(tick_row(100, 2000, 5, 9, 1, WATER_VALVE_CODE));
        plan.push_back(write_row(REG_SCHEDULE_EN, 0));
        plan.push_back(tick_row(-2048, 2047, 7, 31, 0, WATER_VALVE_CODE));
        plan.push_back(tick_row(2047, -2048, 2, 0, 1, WATER_VALVE_CODE));
        plan.push_back(tick_row(1000, 1000, 4, 23, 0, BUFFER_VALVE_CODE));

        repeat (12) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        foreach (plan[i]) begin
            if (plan[i].op == ROW_WRITE) begin
                if (!cfg_busy) begin
                    settle();
                    cfg_busy = 1'b1;
                end
                write_reg(plan[i].reg_idx, plan[i].reg_val);
            end else begin
                if (cfg_busy) begin
                    i_cfg_we <= 1'b0;
                    cfg_busy = 1'b0;
                end
                push_tick(plan[i]);
            end
        end

        for (p = 0; p < N_PHASES; p++) begin
            if (p == 0) begin
                ph_on = '{-1000, -1000};
                ph_off = '{2000, 2000};
            end else if (p == 1) begin
                ph_on = '{2000, 2000};
                ph_off = '{-1000, -1000};
            end else begin
                for (k = 0; k < 2; k++) begin
                    case ($urandom_range(0, 5))
                        0: begin
                            ph_on[k] = -1000;
                            ph_off[k] = int'($urandom_range(0, 3000)) - 1000;
                        end
                        1: begin
                            ph_on[k] = 2000;
                            ph_off[k] = 2000;
                        end
                        default: begin
                            ph_on[k] = int'($urandom_range(0, 900)) - 100;
                            ph_off[k] = ph_on[k] + int'($urandom_range(0, 150));
                        end
                    endcase
                end
            end
            wen = (p < 2) || ($urandom_range(0, 3) != 0);
            ben = (p < 2) || ($urandom_range(0, 3) != 0);
            sen = (p == 0) || (p > 1 && $urandom_range(0, 2) != 0);

            settle();
            write_reg(REG_WATER_ON, 12'(ph_on[0]));
            write_reg(REG_WATER_OFF, 12'(ph_off[0]));
            write_reg(REG_BUFFER_ON, 12'(ph_on[1]));
            write_reg(REG_BUFFER_OFF, 12'(ph_off[1]));
            // upper bits of the flag registers carry junk
            junk = 12'($urandom);
            junk[0] = wen;
            write_reg(REG_WATER_EN, junk);
            junk = 12'($urandom);
            junk[0] = ben;
            write_reg(REG_BUFFER_EN, junk);
            junk = 12'($urandom);
            junk[0] = sen;
            write_reg(REG_SCHEDULE_EN, junk);
            i_cfg_we <= 1'b0;
            n_settings++;
            calm = (p == N_PHASES - 1);

            for (n = 0; n < PHASE_TICKS; n++) begin
                lo = (ph_on[0] < ph_off[0]) ? ph_on[0] : ph_off[0];
                hi = (ph_on[0] < ph_off[0]) ? ph_off[0] : ph_on[0];
                tw = near_temp(lo, hi);
                lo = (ph_on[1] < ph_off[1]) ? ph_on[1] : ph_off[1];
                hi = (ph_on[1] < ph_off[1]) ? ph_off[1] : ph_on[1];
                tb = near_temp(lo, hi);
                // mostly feed back what the current mode commands; sometimes noise
                if ($urandom_range(0, 6) == 0) begin
                    st = 1'($urandom);
                    vl = 1'($urandom);
                end else begin
                    st = (cur_mode != HEAT_OFF);
                    vl = (cur_mode == HEAT_BUF) ? BUFFER_VALVE_CODE : WATER_VALVE_CODE;
                end
                row = tick_row(tw, tb, $urandom_range(0, 7),
                               ($urandom_range(0, 9) == 0) ? $urandom_range(0, 31)
                                                           : $urandom_range(0, 23),
                               st, vl);
                push_tick(row);
            end
        end

        settle();
        $display("Covered %0d poll ticks under %0d random register settings (%0d writes).",
                 n_ticks, n_settings, n_writes);
        $display("Commands expected: %0d mode changes, %0d feedback alerts; mismatches: %0d.",
                 n_changes, n_alerts, mismatches);
        if (mismatches == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/core/bmhc_pkg.sv
rtl/core/bmhc_window.sv
rtl/core/bmhc_mode.sv
rtl/core/boiler_mode_hysteresis_controller.sv
bench/boiler_mode_hysteresis_controller_tb.sv
